>>> rtl/core/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the shifting array table.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int DEPTH   = 8;
	localparam int ENTRY_W = 32;
	localparam int CMD_W   = 3;
	localparam int POS_W   = 3;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

	localparam int SEL_W = 3;
	localparam logic [SEL_W-1:0] SEL_HOLD   = 3'd0;
	localparam logic [SEL_W-1:0] SEL_LOAD   = 3'd1;
	localparam logic [SEL_W-1:0] SEL_LEFT   = 3'd2;
	localparam logic [SEL_W-1:0] SEL_RIGHT  = 3'd3;
	localparam logic [SEL_W-1:0] SEL_MIRROR = 3'd4;
	localparam logic [SEL_W-1:0] SEL_ZERO   = 3'd5;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic [SEL_W-1:0] sel;
		logic             cmp_en;
	} cell_ctl_t;

endpackage

>>> rtl/core/shifting_array_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_array_table_unit
// Register table of signed entries built as a row of cells: insert, replace,
// delete, reverse, search and clear, one request per cycle.
// ----------------------------------------------------------------------------
// Result path: the strobe done rises after a taken start once it has passed
// the cell compare stage, then the priority encoder register.
// Throughput: one request per cycle; busy stays low, the table updates at the
// accepting edge. The receiver cannot stall; every request gives one result.
// Reset: arst_n clears the table to zero and drops any pending result.
module shifting_array_table_unit
	import sat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [POS_W-1:0]   index,
	input  logic signed [31:0] value,
	output logic               done,
	output logic               found,
	output logic [2:0]         found_index
);

	entry_t          entry_w [DEPTH];
	logic [DEPTH-1:0] match_s1;
	cell_ctl_t       ctl_w [DEPTH];
	logic            take;
	logic            pos_ok;
	logic            valid_s1;
	logic            hit;
	logic [2:0]      hit_at;
	logic            done_q;
	logic            found_q;
	logic [2:0]      found_index_q;
	logic            table_nz;

	assign busy   = 1'b0;
	assign take   = start && !busy;
	assign pos_ok = 32'(index) < 32'(DEPTH);

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		entry_t left_w;
		entry_t right_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = entry_w[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = entry_w[k+1];
		end

		always_comb begin
			ctl_w[k].sel    = SEL_HOLD;
			ctl_w[k].cmp_en = take && (cmd == CMD_SEARCH);
			if (take) begin
				case (cmd)
					CMD_INSERT: begin
						if (pos_ok && 32'(index) == 32'(k))
							ctl_w[k].sel = SEL_LOAD;
						else if (pos_ok && 32'(index) < 32'(k))
							ctl_w[k].sel = SEL_LEFT;
					end
					CMD_REPLACE: begin
						if (pos_ok && 32'(index) == 32'(k))
							ctl_w[k].sel = SEL_LOAD;
					end
					CMD_DELETE: begin
						if (pos_ok && 32'(index) <= 32'(k))
							ctl_w[k].sel = (k == DEPTH - 1) ? SEL_ZERO : SEL_RIGHT;
					end
					CMD_REVERSE: ctl_w[k].sel = SEL_MIRROR;
					CMD_CLEAR:   ctl_w[k].sel = SEL_ZERO;
					default:     ctl_w[k].sel = SEL_HOLD;
				endcase
			end
		end

		sat_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_w[k]),
			.value    (value),
			.left     (left_w),
			.right    (right_w),
			.mirror   (entry_w[DEPTH-1-k]),
			.entry    (entry_w[k]),
			.match_s1 (match_s1[k])
		);
	end

	always_comb begin
		hit    = 1'b0;
		hit_at = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (match_s1[k]) begin
				hit    = 1'b1;
				hit_at = 3'(k);
			end
		end
	end

	always_comb begin
		table_nz = 1'b0;
		for (int k = 0; k < DEPTH; k++)
			table_nz = table_nz | (|entry_w[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			done_q        <= 1'b0;
			found_q       <= 1'b0;
			found_index_q <= '0;
		end else begin
			valid_s1      <= take;
			done_q        <= valid_s1;
			found_q       <= valid_s1 && hit;
			found_index_q <= (valid_s1 && hit) ? hit_at : 3'd0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign found_index = found_index_q;

	a_miss_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (found_index == 3'd0))
		else $error("found_index nonzero on a miss");

	a_found_only_search: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> $past(take && (cmd == CMD_SEARCH), 2))
		else $error("hit reported for a request that was not a search");

	a_done_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##2 done)
		else $error("request produced no result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (cmd == CMD_CLEAR)) |=> !table_nz)
		else $error("table not empty after clear");

endmodule

>>> rtl/core/sat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_cell
// One table entry: loads, shifts from a neighbor, mirrors, clears, compares.
// ----------------------------------------------------------------------------
module sat_cell
	import sat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    value,
	input  entry_t    left,
	input  entry_t    right,
	input  entry_t    mirror,
	output entry_t    entry,
	output logic      match_s1
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			match_s1 <= 1'b0;
		end else begin
			match_s1 <= ctl.cmp_en && (entry_q == value);
			case (ctl.sel)
				SEL_HOLD:   entry_q <= entry_q;
				SEL_LOAD:   entry_q <= value;
				SEL_LEFT:   entry_q <= left;
				SEL_RIGHT:  entry_q <= right;
				SEL_MIRROR: entry_q <= mirror;
				SEL_ZERO:   entry_q <= '0;
				default:    entry_q <= entry_q;
			endcase
		end
	end

	assign entry = entry_q;

endmodule

>>> dv/tb_shifting_array_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shifting_array_table_unit
// Self-checking bench for the shifting array table. Requests go in through
// the start/busy handshake with random gaps. A shadow copy of the table works
// out the search outcome of every accepted request. A checker pairs each done
// strobe with the oldest outstanding outcome and compares found and
// found_index. Directed tests cover the edge values, every command and the
// unused codes. A weighted random mix then keeps the table at varied fill
// levels so that searches both hit and miss.
// ----------------------------------------------------------------------------
module tb_shifting_array_table_unit;
	import sat_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int RANDOM_REQUESTS = 1900;
	localparam int BATCH_LEN       = 40;
	localparam int DRAIN_CYCLES    = 4;

	typedef struct packed {
		logic       found;
		logic [2:0] found_index;
	} lookup_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   cmd;
	logic [POS_W-1:0]   index;
	logic signed [31:0] value;
	logic               done;
	logic               found;
	logic [2:0]         found_index;

	entry_t  shadow_entries [DEPTH];
	lookup_t expected_lookups [$];
	int      mismatch_count;
	int      burst_mode;

	shifting_array_table_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.done       (done),
		.found      (found),
		.found_index(found_index)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic lookup_t table_apply(input logic [CMD_W-1:0] c,
			input logic [POS_W-1:0] pos, input entry_t val);
		lookup_t r;
		entry_t  t;
		int      p;
		r = '0;
		p = int'(pos);
		case (c)
			CMD_INSERT: begin
				if (p < DEPTH) begin
					for (int k = DEPTH - 1; k > p; k--)
						shadow_entries[k] = shadow_entries[k-1];
					shadow_entries[p] = val;
				end
			end
			CMD_REPLACE: begin
				if (p < DEPTH)
					shadow_entries[p] = val;
			end
			CMD_DELETE: begin
				if (p < DEPTH) begin
					for (int k = p; k + 1 < DEPTH; k++)
						shadow_entries[k] = shadow_entries[k+1];
					shadow_entries[DEPTH-1] = '0;
				end
			end
			CMD_REVERSE: begin
				for (int k = 0; k < DEPTH / 2; k++) begin
					t = shadow_entries[k];
					shadow_entries[k] = shadow_entries[DEPTH-1-k];
					shadow_entries[DEPTH-1-k] = t;
				end
			end
			CMD_SEARCH: begin
				for (int k = 0; k < DEPTH; k++) begin
					if (!r.found && shadow_entries[k] == val) begin
						r.found = 1'b1;
						r.found_index = k[2:0];
					end
				end
			end
			CMD_CLEAR: begin
				for (int k = 0; k < DEPTH; k++)
					shadow_entries[k] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic send_request(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] pos,
			input entry_t val);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		index <= pos;
		value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_lookups.push_back(table_apply(c, pos, val));
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (burst_mode != 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic entry_t pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			case ($urandom_range(0, 7))
				0: return 32'sh0000_0000;
				1: return 32'sh0000_0001;
				2: return 32'shFFFF_FFFF;
				3: return 32'sh8000_0000;
				4: return 32'sh7FFF_FFFF;
				5: return 32'sh5555_5555;
				6: return 32'shAAAA_AAAA;
				default: return entry_t'($urandom_range(2, 9));
			endcase
		end
		if (r < 65)
			return shadow_entries[$urandom_range(0, DEPTH - 1)];
		return entry_t'($urandom);
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(input int mode);
		int r;
		int ins_w;
		int del_w;
		ins_w = (mode == 1) ? 40 : (mode == 2) ? 8 : 22;
		del_w = (mode == 2) ? 40 : (mode == 1) ? 6 : 16;
		r = $urandom_range(0, ins_w + del_w + 64);
		if (r < ins_w)
			return CMD_INSERT;
		r -= ins_w;
		if (r < del_w)
			return CMD_DELETE;
		r -= del_w;
		if (r < 16)
			return CMD_REPLACE;
		if (r < 24)
			return CMD_REVERSE;
		if (r < 58)
			return CMD_SEARCH;
		if (r < 61)
			return CMD_CLEAR;
		return (r < 63) ? CMD_SPARE_A : CMD_SPARE_B;
	endfunction

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				report_mismatch("unexpected done", 1, 0);
			end else begin
				want = expected_lookups.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (found_index !== want.found_index)
					report_mismatch("found_index", found_index, want.found_index);
			end
		end
	end

	task automatic test_empty_table();
		send_request(CMD_SEARCH, 3'd5, 32'sh0000_0000);
		send_request(CMD_SEARCH, 3'd2, 32'sh7FFF_FFFF);
	endtask

	task automatic test_edge_values();
		send_request(CMD_INSERT, 3'd0, 32'sh7FFF_FFFF);
		idle_for(2);
		send_request(CMD_INSERT, 3'd7, 32'sh8000_0000);
		send_request(CMD_INSERT, 3'd3, 32'shFFFF_FFFF);
		send_request(CMD_SEARCH, 3'd0, 32'sh8000_0000);
		send_request(CMD_REPLACE, 3'd7, 32'sh5555_5555);
		send_request(CMD_REPLACE, 3'd0, 32'shAAAA_AAAA);
		send_request(CMD_SEARCH, 3'd7, 32'shAAAA_AAAA);
	endtask

	task automatic test_each_command();
		send_request(CMD_REVERSE, 3'd4, 32'sh1234_5678);
		send_request(CMD_SEARCH, 3'd0, 32'shAAAA_AAAA);
		idle_for(1);
		send_request(CMD_DELETE, 3'd0, 32'sh0000_0000);
		send_request(CMD_DELETE, 3'd7, 32'shFFFF_FFFF);
		send_request(CMD_SEARCH, 3'd1, 32'shFFFF_FFFF);
		send_request(CMD_SPARE_A, 3'd6, 32'shFFFF_FFFF);
		send_request(CMD_SPARE_B, 3'd1, 32'sh0000_0000);
		send_request(CMD_SEARCH, 3'd0, 32'sh5555_5555);
		send_request(CMD_CLEAR, 3'd7, 32'sh7FFF_FFFF);
		send_request(CMD_SEARCH, 3'd0, 32'sh5555_5555);
		send_request(CMD_SEARCH, 3'd0, 32'sh0000_0000);
	endtask

	task automatic test_random_mix(input int count);
		int mode;
		mode = 0;
		for (int n = 0; n < count; n++) begin
			if (n % BATCH_LEN == 0) begin
				mode = $urandom_range(0, 2);
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			send_request(pick_cmd(mode), POS_W'($urandom_range(0, 7)), pick_value());
			idle_for(pick_gap());
		end
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = CMD_INSERT;
		index  = '0;
		value  = '0;
		mismatch_count = 0;
		burst_mode = 0;
		for (int k = 0; k < DEPTH; k++)
			shadow_entries[k] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		idle_for(2);

		test_empty_table();
		test_edge_values();
		test_each_command();
		test_random_mix(RANDOM_REQUESTS);

		@(negedge clk);
		start <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
